[src/pmt_pkg.sv]
// Shared types, constants and command codes of the polyline margin trimmer.
package pmt_pkg;

    localparam int CoordBits  = 32;
    localparam int FracBits   = 16;
    localparam int FracW      = FracBits + 1;
    localparam int MarginBits = 32;
    localparam int CmdBits    = 2;
    localparam int KindBits   = 2;
    localparam int PAddrBits  = 3;
    localparam int PDataBits  = 32;

    localparam logic [FracW-1:0] FracOne  = FracW'(1) << FracBits;
    localparam logic [FracW-1:0] FracHalf = FracW'(1) << (FracBits - 1);

    localparam logic [CmdBits-1:0] CmdBegin  = 2'd0;
    localparam logic [CmdBits-1:0] CmdMargin = 2'd1;
    localparam logic [CmdBits-1:0] CmdPoint  = 2'd2;
    localparam logic [CmdBits-1:0] CmdFinish = 2'd3;

    localparam logic [KindBits-1:0] KindLine  = 2'd0;
    localparam logic [KindBits-1:0] KindJoin  = 2'd1;
    localparam logic [KindBits-1:0] KindClose = 2'd2;

    localparam logic [PAddrBits-3:0] RegClosePath = 1'b0;

    typedef logic signed [CoordBits-1:0] t_coord;
    typedef logic [FracW-1:0]            t_frac;

    typedef struct packed {
        logic [CmdBits-1:0]           command;
        logic signed [CoordBits-1:0]  point_x;
        logic signed [CoordBits-1:0]  point_y;
        logic signed [MarginBits-1:0] margin_value;
    } t_in_item;

    typedef struct packed {
        logic [KindBits-1:0]         prim_kind;
        logic signed [CoordBits-1:0] ax;
        logic signed [CoordBits-1:0] ay;
        logic signed [CoordBits-1:0] bx;
        logic signed [CoordBits-1:0] by;
        logic signed [CoordBits-1:0] cx;
        logic signed [CoordBits-1:0] cy;
        logic                        last_of_run;
    } t_out_item;

    typedef struct packed {
        logic emit_join;
        logic emit_line;
        logic emit_close;
        logic ends_item;
    } t_trim_flags;

    typedef struct packed {
        logic signed [CoordBits-1:0] prev_x;
        logic signed [CoordBits-1:0] prev_y;
        logic signed [CoordBits-1:0] p_x;
        logic signed [CoordBits-1:0] p_y;
        logic signed [CoordBits-1:0] d_x;
        logic signed [CoordBits-1:0] d_y;
        logic signed [CoordBits:0]   nd_x;
        logic signed [CoordBits:0]   nd_y;
        logic [FracW-1:0]            start_frac;
        logic [FracW-1:0]            end_frac;
        t_trim_flags                 flags;
    } t_trim_cmd;

endpackage

[src/pmt_front.sv]
// Front end: accepts items, tracks counts, fractions and vertices, and issues trim commands.
module pmt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pmt_pkg::t_in_item   i_in_data,
    input  logic                i_close_path,
    input  logic                i_q_full,
    output logic                o_push,
    output pmt_pkg::t_trim_cmd  o_push_cmd
);

    logic [1:0]            r_ps;
    logic [1:0]            r_ms;
    pmt_pkg::t_frac        r_sf;
    pmt_pkg::t_frac        r_ef;
    logic                  r_fin_pend;
    pmt_pkg::t_coord       r_pv_x;
    pmt_pkg::t_coord       r_pv_y;
    pmt_pkg::t_coord       r_fv_x [2];
    pmt_pkg::t_coord       r_fv_y [2];
    pmt_pkg::t_frac        r_ff_s;
    pmt_pkg::t_frac        r_ff_e;

    logic                                      accept;
    logic                                      closing;
    logic signed [pmt_pkg::MarginBits-1:0]     mv;
    pmt_pkg::t_frac                            clamp_first;
    pmt_pkg::t_frac                            max_second;
    pmt_pkg::t_frac                            clamp_second;
    pmt_pkg::t_trim_flags                      fl_point;
    pmt_pkg::t_trim_flags                      fl_close1;
    pmt_pkg::t_trim_flags                      fl_close2;

    function automatic pmt_pkg::t_trim_cmd mk_cmd(
        input pmt_pkg::t_coord      prev_x,
        input pmt_pkg::t_coord      prev_y,
        input pmt_pkg::t_coord      p_x,
        input pmt_pkg::t_coord      p_y,
        input pmt_pkg::t_frac       s,
        input pmt_pkg::t_frac       e,
        input pmt_pkg::t_trim_flags fl
    );
        pmt_pkg::t_trim_cmd c;
        pmt_pkg::t_coord    dx;
        pmt_pkg::t_coord    dy;
        dx           = p_x - prev_x;
        dy           = p_y - prev_y;
        c.prev_x     = prev_x;
        c.prev_y     = prev_y;
        c.p_x        = p_x;
        c.p_y        = p_y;
        c.d_x        = dx;
        c.d_y        = dy;
        c.nd_x       = (pmt_pkg::CoordBits+1)'(0) - {dx[pmt_pkg::CoordBits-1], dx};
        c.nd_y       = (pmt_pkg::CoordBits+1)'(0) - {dy[pmt_pkg::CoordBits-1], dy};
        c.start_frac = s;
        c.end_frac   = e;
        c.flags      = fl;
        return c;
    endfunction

    assign o_in_ready = !r_fin_pend && !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign closing    = i_close_path && r_ps[1];
    assign mv         = i_in_data.margin_value;

    always_comb begin
        if (mv < 0) begin
            clamp_first = '0;
        end else if (mv > $signed(pmt_pkg::MarginBits'(pmt_pkg::FracOne))) begin
            clamp_first = pmt_pkg::FracOne;
        end else begin
            clamp_first = mv[pmt_pkg::FracW-1:0];
        end
        max_second = pmt_pkg::FracOne - r_sf;
        if (mv > $signed(pmt_pkg::MarginBits'(max_second))) begin
            clamp_second = max_second;
        end else if (mv < 0) begin
            clamp_second = '0;
        end else begin
            clamp_second = mv[pmt_pkg::FracW-1:0];
        end
    end

    always_comb begin
        fl_point   = '{emit_join: r_ps[1], emit_line: 1'b1, emit_close: 1'b0, ends_item: 1'b1};
        fl_close1  = '{emit_join: 1'b1, emit_line: 1'b1, emit_close: 1'b0, ends_item: 1'b0};
        fl_close2  = '{emit_join: 1'b1, emit_line: 1'b0, emit_close: 1'b1, ends_item: 1'b1};
        o_push     = 1'b0;
        o_push_cmd = mk_cmd(r_pv_x, r_pv_y, i_in_data.point_x, i_in_data.point_y,
                            r_sf, r_ef, fl_point);
        priority if (r_fin_pend) begin
            o_push     = !i_q_full;
            o_push_cmd = mk_cmd(r_fv_x[0], r_fv_y[0], r_fv_x[1], r_fv_y[1],
                                r_ff_s, r_ff_e, fl_close2);
        end else if (accept && i_in_data.command == pmt_pkg::CmdPoint) begin
            o_push = r_ps != 2'd0;
        end else if (accept && i_in_data.command == pmt_pkg::CmdFinish && closing) begin
            o_push     = 1'b1;
            o_push_cmd = mk_cmd(r_pv_x, r_pv_y, r_fv_x[0], r_fv_y[0], r_sf, r_ef, fl_close1);
        end else begin
            o_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps       <= 2'd0;
            r_ms       <= 2'd0;
            r_sf       <= '0;
            r_ef       <= '0;
            r_fin_pend <= 1'b0;
        end else begin
            if (r_fin_pend && !i_q_full) begin
                r_fin_pend <= 1'b0;
            end
            if (accept) begin
                unique case (i_in_data.command)
                    pmt_pkg::CmdBegin: begin
                        r_ps <= 2'd0;
                        r_ms <= 2'd0;
                        r_sf <= '0;
                        r_ef <= '0;
                    end
                    pmt_pkg::CmdMargin: begin
                        if (r_ms == 2'd0) begin
                            r_sf <= clamp_first;
                            r_ef <= (clamp_first < pmt_pkg::FracHalf) ? clamp_first
                                  : pmt_pkg::FracOne - clamp_first;
                            r_ms <= 2'd1;
                        end else if (r_ms == 2'd1) begin
                            r_ef <= clamp_second;
                            r_ms <= 2'd2;
                        end
                    end
                    pmt_pkg::CmdPoint: begin
                        r_ps <= r_ps[1] ? 2'd2 : r_ps + 2'd1;
                        r_ms <= 2'd0;
                        r_sf <= r_ef;
                        r_ef <= r_sf;
                    end
                    pmt_pkg::CmdFinish: begin
                        if (closing) begin
                            r_fin_pend <= 1'b1;
                            r_sf       <= r_ff_e;
                            r_ef       <= r_ff_s;
                        end
                        r_ps <= 2'd0;
                        r_ms <= 2'd0;
                    end
                    default: begin
                        r_ps <= r_ps;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in_data.command == pmt_pkg::CmdPoint) begin
            r_pv_x <= i_in_data.point_x;
            r_pv_y <= i_in_data.point_y;
            if (!r_ps[1]) begin
                r_fv_x[r_ps[0]] <= i_in_data.point_x;
                r_fv_y[r_ps[0]] <= i_in_data.point_y;
            end
            if (r_ps == 2'd1) begin
                r_ff_s <= r_sf;
                r_ff_e <= r_ef;
            end
        end else if (accept && i_in_data.command == pmt_pkg::CmdFinish && closing) begin
            r_pv_x <= r_fv_x[1];
            r_pv_y <= r_fv_y[1];
        end
    end

endmodule

[src/pmt_queue.sv]
// Short command queue between the front end and the trim unit.
module pmt_queue #(
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pmt_pkg::t_trim_cmd i_push_cmd,
    output logic               o_full,
    output logic               o_valid,
    output pmt_pkg::t_trim_cmd o_cmd,
    input  logic               i_pop
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

    pmt_pkg::t_trim_cmd r_mem [DEPTH];
    logic [PtrW-1:0]    r_wr;
    logic [PtrW-1:0]    r_rd;
    logic [CntW-1:0]    r_count;

    assign o_full  = r_count == CntW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LastPtr) ? '0 : r_wr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LastPtr) ? '0 : r_rd + PtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

endmodule

[src/pmt_back.sv]
// Trim unit: scales segment deltas by the fractions and emits join, line and close items.
module pmt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  pmt_pkg::t_trim_cmd  i_q_cmd,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pmt_pkg::t_out_item  o_out_data
);

    localparam int Cb = pmt_pkg::CoordBits;
    localparam int Fb = pmt_pkg::FracBits;

    logic                 r_e_valid;
    pmt_pkg::t_trim_flags r_e_flags;
    pmt_pkg::t_coord      r_e_prev_x;
    pmt_pkg::t_coord      r_e_prev_y;
    pmt_pkg::t_coord      r_e_p_x;
    pmt_pkg::t_coord      r_e_p_y;
    pmt_pkg::t_coord      r_e_sa_x;
    pmt_pkg::t_coord      r_e_sa_y;
    pmt_pkg::t_coord      r_e_sb_x;
    pmt_pkg::t_coord      r_e_sb_y;
    pmt_pkg::t_coord      r_pte_x;
    pmt_pkg::t_coord      r_pte_y;
    logic                 r_out_valid;
    pmt_pkg::t_out_item   r_out;

    logic signed [Cb+Fb+1:0] prod_sx;
    logic signed [Cb+Fb+1:0] prod_sy;
    logic signed [Cb+Fb+2:0] prod_ex;
    logic signed [Cb+Fb+2:0] prod_ey;
    pmt_pkg::t_coord         a_x;
    pmt_pkg::t_coord         a_y;
    pmt_pkg::t_coord         b_x;
    pmt_pkg::t_coord         b_y;
    logic                    out_load;
    logic                    e_done;
    logic                    emit_line_now;
    pmt_pkg::t_trim_flags    n_e_flags;
    pmt_pkg::t_out_item      n_out;

    assign prod_sx = $signed(i_q_cmd.d_x) * $signed({1'b0, i_q_cmd.start_frac});
    assign prod_sy = $signed(i_q_cmd.d_y) * $signed({1'b0, i_q_cmd.start_frac});
    assign prod_ex = $signed(i_q_cmd.nd_x) * $signed({1'b0, i_q_cmd.end_frac});
    assign prod_ey = $signed(i_q_cmd.nd_y) * $signed({1'b0, i_q_cmd.end_frac});

    assign a_x = r_e_prev_x + r_e_sa_x;
    assign a_y = r_e_prev_y + r_e_sa_y;
    assign b_x = r_e_p_x + r_e_sb_x;
    assign b_y = r_e_p_y + r_e_sb_y;

    assign out_load = r_e_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_e_flags     = r_e_flags;
        n_out         = '0;
        emit_line_now = 1'b0;
        priority if (r_e_flags.emit_join) begin
            n_e_flags.emit_join = 1'b0;
            n_out.prim_kind     = pmt_pkg::KindJoin;
            n_out.ax            = r_pte_x;
            n_out.ay            = r_pte_y;
            n_out.bx            = r_e_prev_x;
            n_out.by            = r_e_prev_y;
            n_out.cx            = a_x;
            n_out.cy            = a_y;
        end else if (r_e_flags.emit_line) begin
            n_e_flags.emit_line = 1'b0;
            emit_line_now       = 1'b1;
            n_out.prim_kind     = pmt_pkg::KindLine;
            n_out.ax            = a_x;
            n_out.ay            = a_y;
            n_out.bx            = b_x;
            n_out.by            = b_y;
        end else begin
            n_e_flags.emit_close = 1'b0;
            n_out.prim_kind      = pmt_pkg::KindClose;
        end
        e_done            = out_load && !n_e_flags.emit_join && !n_e_flags.emit_line
                          && !n_e_flags.emit_close;
        n_out.last_of_run = r_e_flags.ends_item && !n_e_flags.emit_join
                          && !n_e_flags.emit_line && !n_e_flags.emit_close;
    end

    assign o_q_pop     = i_q_valid && (!r_e_valid || e_done);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid   <= 1'b0;
            r_e_flags   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_e_valid <= 1'b1;
                r_e_flags <= i_q_cmd.flags;
            end else if (out_load) begin
                r_e_valid <= !e_done;
                r_e_flags <= n_e_flags;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_e_prev_x <= i_q_cmd.prev_x;
            r_e_prev_y <= i_q_cmd.prev_y;
            r_e_p_x    <= i_q_cmd.p_x;
            r_e_p_y    <= i_q_cmd.p_y;
            r_e_sa_x   <= prod_sx[Fb +: Cb];
            r_e_sa_y   <= prod_sy[Fb +: Cb];
            r_e_sb_x   <= prod_ex[Fb +: Cb];
            r_e_sb_y   <= prod_ey[Fb +: Cb];
        end
        if (out_load) begin
            r_out <= n_out;
        end
        if (out_load && emit_line_now) begin
            r_pte_x <= b_x;
            r_pte_y <= b_y;
        end
    end

endmodule

[src/polyline_margin_trimmer.sv]
// Top level of the polyline margin trimmer: configuration register, front end, queue, trim unit.
// Point and finish items pass the queue, trim stage registers and output register. Line-only
// point items pass one per cycle and the trim unit emits one item per cycle, unless the output
// stalls; it takes a command once the last one's items are out. A closing finish holds the
// input until its second command is queued; it emits four items. Reset, synchronous and active
// low, clears counts, fractions, close_path, the queue and all valid flags; vertex stores stay.
module polyline_margin_trimmer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  pmt_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output pmt_pkg::t_out_item                o_out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pmt_pkg::PAddrBits-1:0]     paddr,
    input  logic [pmt_pkg::PDataBits-1:0]     pwdata,
    output logic [pmt_pkg::PDataBits-1:0]     prdata,
    output logic                              pready
);

    logic               r_close_path;
    logic               reg_hit;
    logic               q_full;
    logic               q_push;
    logic               q_valid;
    logic               q_pop;
    pmt_pkg::t_trim_cmd q_push_cmd;
    pmt_pkg::t_trim_cmd q_cmd;

    assign pready  = 1'b1;
    assign reg_hit = paddr[pmt_pkg::PAddrBits-1:2] == pmt_pkg::RegClosePath;
    assign prdata  = reg_hit ? {{(pmt_pkg::PDataBits-1){1'b0}}, r_close_path} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_close_path <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_close_path <= pwdata[0];
        end
    end

    pmt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_close_path (r_close_path),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_push_cmd   (q_push_cmd)
    );

    pmt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_push_cmd),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_cmd      (q_cmd),
        .i_pop      (q_pop)
    );

    pmt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[src/pmt_checker.sv]
// Port-level checker for the polyline margin trimmer and its bind statement.
module pmt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input pmt_pkg::t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Output item dropped before it was taken.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("Output item changed while stalled.");

    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.prim_kind == pmt_pkg::KindClose |-> o_out_data.last_of_run)
        else $error("Close marker is not the last item of its run.");

    a_close_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.prim_kind == pmt_pkg::KindClose
        |-> o_out_data.ax == '0 && o_out_data.ay == '0 && o_out_data.bx == '0
            && o_out_data.by == '0 && o_out_data.cx == '0 && o_out_data.cy == '0)
        else $error("Close marker carries coordinates.");

    a_line_c_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.prim_kind == pmt_pkg::KindLine
        |-> o_out_data.cx == '0 && o_out_data.cy == '0)
        else $error("Line item carries a third point.");

endmodule

bind polyline_margin_trimmer pmt_checker u_pmt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
